@@ rtl/mfp_pkg.sv @@
// ----------------------------------------------------------------------------
// mfp_pkg - shared types and constants of the MSP v1 frame parser
// Word formats of the request and response channels, per-packet state and
// the codes used in status results and register writes.
// ----------------------------------------------------------------------------
package mfp_pkg;

   // request word: one frame byte plus the end-of-packet mark
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       packet_end;
   } req_word_type;

   // response word: payload byte or packet status
   typedef struct packed {
      logic       result_kind;
      logic [7:0] payload_value;
      logic [7:0] payload_position;
      logic [2:0] packet_status;
      logic [1:0] direction_code;
      logic [7:0] command_code;
      logic [7:0] payload_length;
   } rsp_word_type;

   // per-packet parse state, cleared after every packet end
   typedef struct packed {
      logic [8:0] byte_position;
      logic       header_good;
      logic [1:0] direction_seen;
      logic [7:0] command_seen;
      logic [7:0] length_seen;
      logic [7:0] running_xor;
      logic [7:0] checksum_byte;
   } frame_state_type;

   localparam frame_state_type FRAME_STATE_CLEAR = '{
      byte_position:  9'd0,
      header_good:    1'b1,
      direction_seen: 2'd0,
      command_seen:   8'd0,
      length_seen:    8'd0,
      running_xor:    8'd0,
      checksum_byte:  8'd0
   };

   // byte positions within a frame
   localparam logic [8:0] POS_HEADER0   = 9'd0;
   localparam logic [8:0] POS_HEADER1   = 9'd1;
   localparam logic [8:0] POS_DIRECTION = 9'd2;
   localparam logic [8:0] POS_LENGTH    = 9'd3;
   localparam logic [8:0] POS_COMMAND   = 9'd4;
   localparam logic [8:0] POS_PAYLOAD   = 9'd5;
   localparam logic [8:0] POS_MAX       = 9'd511;

   // length rules: minimum frame and overhead beyond the payload
   localparam logic [9:0] MIN_FRAME_BYTES = 10'd7;
   localparam logic [9:0] FRAME_OVERHEAD  = 10'd6;

   // direction bytes and codes
   localparam logic [7:0] DIR_BYTE_IN  = 8'h3C;  // '<'
   localparam logic [7:0] DIR_BYTE_OUT = 8'h3E;  // '>'
   localparam logic [1:0] DIR_INBOUND  = 2'd0;
   localparam logic [1:0] DIR_OUTBOUND = 2'd1;
   localparam logic [1:0] DIR_INVALID  = 2'd2;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // packet status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_HEADER   = 3'd1;
   localparam logic [2:0] STATUS_LENGTH   = 3'd2;
   localparam logic [2:0] STATUS_FIELD    = 3'd3;
   localparam logic [2:0] STATUS_CHECKSUM = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_HEADER_FIRST  = 3'd0;
   localparam logic [2:0] CSR_HEADER_SECOND = 3'd1;
   localparam logic [2:0] CSR_CMD_VALID0    = 3'd2;
   localparam logic [2:0] CSR_CMD_VALID1    = 3'd3;
   localparam logic [2:0] CSR_CMD_VALID2    = 3'd4;
   localparam logic [2:0] CSR_CMD_VALID3    = 3'd5;

   // register reset values
   localparam logic [7:0] HEADER_FIRST_RESET  = 8'h24;  // '$'
   localparam logic [7:0] HEADER_SECOND_RESET = 8'h4D;  // 'M'

endpackage

@@ rtl/mfp_byte_decode.sv @@
// ----------------------------------------------------------------------------
// mfp_byte_decode - per-byte frame decode
// Takes the parse state and one frame byte, gives the next state and the
// response word the byte causes, if any.
// ----------------------------------------------------------------------------
module mfp_byte_decode (
   input  mfp_pkg::frame_state_type state_cur,
   input  mfp_pkg::req_word_type    byte_word,
   input  logic [7:0]               header_first,
   input  logic [7:0]               header_second,
   input  logic [255:0]             cmd_valid_map,
   output mfp_pkg::frame_state_type state_next,
   output logic                     result_valid,
   output mfp_pkg::rsp_word_type    result_word
);

   mfp_pkg::frame_state_type upd;
   logic [8:0]               idx;
   logic [8:0]               offset;
   logic [7:0]               b;
   logic                     is_payload;
   logic [9:0]               count;
   logic [9:0]               length_need;
   logic [2:0]               status;

   assign idx         = state_cur.byte_position;
   assign b           = byte_word.frame_byte;
   assign offset      = idx - mfp_pkg::POS_PAYLOAD;

   always_comb begin
      upd        = state_cur;
      is_payload = 1'b0;
      priority if (idx == mfp_pkg::POS_HEADER0) begin
         if (b != header_first) upd.header_good = 1'b0;
      end else if (idx == mfp_pkg::POS_HEADER1) begin
         if (b != header_second) upd.header_good = 1'b0;
      end else if (idx == mfp_pkg::POS_DIRECTION) begin
         priority if (b == mfp_pkg::DIR_BYTE_IN) upd.direction_seen = mfp_pkg::DIR_INBOUND;
         else if (b == mfp_pkg::DIR_BYTE_OUT) upd.direction_seen = mfp_pkg::DIR_OUTBOUND;
         else upd.direction_seen = mfp_pkg::DIR_INVALID;
      end else if (idx == mfp_pkg::POS_LENGTH) begin
         upd.length_seen = b;
         upd.running_xor = state_cur.running_xor ^ b;
      end else if (idx == mfp_pkg::POS_COMMAND) begin
         upd.command_seen = b;
         upd.running_xor  = state_cur.running_xor ^ b;
      end else if (idx != mfp_pkg::POS_MAX) begin
         if (offset < {1'b0, state_cur.length_seen}) begin
            upd.running_xor = state_cur.running_xor ^ b;
            is_payload      = 1'b1;
         end else if (offset == {1'b0, state_cur.length_seen}) begin
            upd.checksum_byte = b;
         end
      end else begin
         // count saturated: drop the byte as trailing data
      end
      // saturate the byte count
      if (idx != mfp_pkg::POS_MAX) upd.byte_position = idx + 9'd1;
   end

   assign count       = {1'b0, idx} + 10'd1;
   assign length_need = {2'b00, upd.length_seen} + mfp_pkg::FRAME_OVERHEAD;

   always_comb begin
      priority if (!upd.header_good) begin
         status = mfp_pkg::STATUS_HEADER;
      end else if (count < mfp_pkg::MIN_FRAME_BYTES || count < length_need) begin
         status = mfp_pkg::STATUS_LENGTH;
      end else if (upd.direction_seen == mfp_pkg::DIR_INVALID ||
                   !cmd_valid_map[upd.command_seen]) begin
         status = mfp_pkg::STATUS_FIELD;
      end else if (upd.running_xor != upd.checksum_byte) begin
         status = mfp_pkg::STATUS_CHECKSUM;
      end else begin
         status = mfp_pkg::STATUS_OK;
      end
   end

   always_comb begin
      result_word.direction_code = upd.direction_seen;
      result_word.command_code   = upd.command_seen;
      result_word.payload_length = upd.length_seen;
      if (byte_word.packet_end) begin
         result_valid                 = 1'b1;
         result_word.result_kind      = mfp_pkg::KIND_STATUS;
         result_word.payload_value    = 8'd0;
         result_word.payload_position = 8'd0;
         result_word.packet_status    = status;
         state_next                   = mfp_pkg::FRAME_STATE_CLEAR;
      end else begin
         result_valid                 = is_payload;
         result_word.result_kind      = mfp_pkg::KIND_PAYLOAD;
         result_word.payload_value    = b;
         result_word.payload_position = offset[7:0];
         result_word.packet_status    = mfp_pkg::STATUS_OK;
         state_next                   = upd;
      end
   end

endmodule

@@ rtl/msp_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// msp_frame_parser_unit - MSP v1 parser, one byte per cycle unless stalled
// Path: an accepted req word sits in the input reg (s1), is decoded, and
// any result it yields goes to the response reg, where it waits to be taken.
// Throughput: one word per cycle unless stalled; single decode stage.
// Reset: synchronous; clears the parse state and loads default registers.
// ----------------------------------------------------------------------------
module msp_frame_parser_unit (
   input  logic                  clock,
   input  logic                  reset,
   // request channel: frame bytes
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mfp_pkg::req_word_type req_word,
   // response channel: payload bytes and packet status
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mfp_pkg::rsp_word_type rsp_word,
   // configuration write port
   input  logic                  csr_write_en,
   input  logic [2:0]            csr_index,
   input  logic [63:0]           csr_write_data
);

   // Configuration registers: expected header bytes and the 256-bit map of
   // valid command codes (bit c marks command c as valid).
   logic [7:0]   header_first_ff;
   logic [7:0]   header_second_ff;
   logic [255:0] cmd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= mfp_pkg::HEADER_FIRST_RESET;
         header_second_ff <= mfp_pkg::HEADER_SECOND_RESET;
         cmd_valid_ff     <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mfp_pkg::CSR_HEADER_FIRST:  header_first_ff       <= csr_write_data[7:0];
            mfp_pkg::CSR_HEADER_SECOND: header_second_ff      <= csr_write_data[7:0];
            mfp_pkg::CSR_CMD_VALID0:    cmd_valid_ff[63:0]    <= csr_write_data;
            mfp_pkg::CSR_CMD_VALID1:    cmd_valid_ff[127:64]  <= csr_write_data;
            mfp_pkg::CSR_CMD_VALID2:    cmd_valid_ff[191:128] <= csr_write_data;
            mfp_pkg::CSR_CMD_VALID3:    cmd_valid_ff[255:192] <= csr_write_data;
            default: begin
               // unused indexes: drop the write
            end
         endcase
      end
   end

   // Pipeline: input register (s1) -> decode -> response register.
   // The s1 word advances whenever the response register is empty or is
   // being taken this cycle; a word that yields no response still advances
   // and updates the parse state.
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   mfp_pkg::req_word_type     s1_word_ff;
   mfp_pkg::frame_state_type  state_ff;
   mfp_pkg::frame_state_type  state_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   mfp_pkg::rsp_word_type     rsp_word_ff;

   logic                      out_free;
   logic                      s1_fire;
   logic                      req_take;
   mfp_pkg::frame_state_type  dec_state;
   logic                      dec_valid;
   mfp_pkg::rsp_word_type     dec_word;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   // hold the requester only while a word waits in s1 and cannot advance
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   mfp_byte_decode u_decode (
      .state_cur     (state_ff),
      .byte_word     (s1_word_ff),
      .header_first  (header_first_ff),
      .header_second (header_second_ff),
      .cmd_valid_map (cmd_valid_ff),
      .state_next    (dec_state),
      .result_valid  (dec_valid),
      .result_word   (dec_word)
   );

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_fire);
      state_in     = s1_fire ? dec_state : state_ff;
      // load a new response on a decoded result, otherwise clear once taken
      if (s1_fire && dec_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= mfp_pkg::FRAME_STATE_CLEAR;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_take) s1_word_ff <= req_word;
      if (s1_fire && dec_valid) rsp_word_ff <= dec_word;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ dv/msp_frame_parser_unit_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msp_frame_parser_unit_check - frame parser scoreboard
// Watches the request, response and register ports, tracks the parse state
// of each packet, and compares every response word with the predicted one.
// ----------------------------------------------------------------------------
module msp_frame_parser_unit_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  mfp_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  mfp_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_en,
   input  logic [2:0]            csr_index,
   input  logic [63:0]           csr_write_data,
   output int                    error_count,
   output int                    pending_count,
   output int                    status_words,
   output int                    payload_words,
   output logic [4:0]            status_mask
);

   logic [7:0]               hdr_first;
   logic [7:0]               hdr_second;
   logic [255:0]             cmd_valid_map;
   mfp_pkg::frame_state_type parse;
   mfp_pkg::rsp_word_type    expected_q[$];

   int              mismatch_total = 0;
   int              waiting = 0;
   int              status_total = 0;
   int              payload_total = 0;
   logic [4:0]      seen_status = '0;

   assign error_count   = mismatch_total;
   assign pending_count = waiting;
   assign status_words  = status_total;
   assign payload_words = payload_total;
   assign status_mask   = seen_status;

   task automatic apply_write(input logic [2:0] idx, input logic [63:0] data);
      case (idx)
         mfp_pkg::CSR_HEADER_FIRST:  hdr_first  = data[7:0];
         mfp_pkg::CSR_HEADER_SECOND: hdr_second = data[7:0];
         mfp_pkg::CSR_CMD_VALID0:    cmd_valid_map[63:0]    = data;
         mfp_pkg::CSR_CMD_VALID1:    cmd_valid_map[127:64]  = data;
         mfp_pkg::CSR_CMD_VALID2:    cmd_valid_map[191:128] = data;
         mfp_pkg::CSR_CMD_VALID3:    cmd_valid_map[255:192] = data;
         default: ;
      endcase
   endtask

   // advance the parse by one frame byte and queue the word it causes
   task automatic parse_byte(input logic [7:0] b, input logic last);
      logic [8:0]            idx;
      logic [9:0]            offset;
      logic [9:0]            count;
      logic                  is_payload;
      logic [7:0]            ppos;
      mfp_pkg::rsp_word_type w;
      idx        = parse.byte_position;
      is_payload = 1'b0;
      ppos       = 8'd0;
      if (idx == mfp_pkg::POS_HEADER0) begin
         if (b != hdr_first) parse.header_good = 1'b0;
      end else if (idx == mfp_pkg::POS_HEADER1) begin
         if (b != hdr_second) parse.header_good = 1'b0;
      end else if (idx == mfp_pkg::POS_DIRECTION) begin
         parse.direction_seen = (b == mfp_pkg::DIR_BYTE_IN)  ? mfp_pkg::DIR_INBOUND :
                                (b == mfp_pkg::DIR_BYTE_OUT) ? mfp_pkg::DIR_OUTBOUND :
                                                               mfp_pkg::DIR_INVALID;
      end else if (idx == mfp_pkg::POS_LENGTH) begin
         parse.length_seen = b;
         parse.running_xor = parse.running_xor ^ b;
      end else if (idx == mfp_pkg::POS_COMMAND) begin
         parse.command_seen = b;
         parse.running_xor  = parse.running_xor ^ b;
      end else if (idx < mfp_pkg::POS_MAX) begin
         offset = {1'b0, idx - mfp_pkg::POS_PAYLOAD};
         if (offset < {2'b00, parse.length_seen}) begin
            parse.running_xor = parse.running_xor ^ b;
            is_payload        = 1'b1;
            ppos              = offset[7:0];
         end else if (offset == {2'b00, parse.length_seen}) begin
            parse.checksum_byte = b;
         end
      end
      if (idx < mfp_pkg::POS_MAX) parse.byte_position = idx + 9'd1;

      w                = '0;
      w.direction_code = parse.direction_seen;
      w.command_code   = parse.command_seen;
      w.payload_length = parse.length_seen;
      if (last) begin
         count         = {1'b0, idx} + 10'd1;
         w.result_kind = mfp_pkg::KIND_STATUS;
         if (!parse.header_good)
            w.packet_status = mfp_pkg::STATUS_HEADER;
         else if (count < mfp_pkg::MIN_FRAME_BYTES ||
                  count < {2'b00, parse.length_seen} + mfp_pkg::FRAME_OVERHEAD)
            w.packet_status = mfp_pkg::STATUS_LENGTH;
         else if (parse.direction_seen == mfp_pkg::DIR_INVALID ||
                  !cmd_valid_map[parse.command_seen])
            w.packet_status = mfp_pkg::STATUS_FIELD;
         else if (parse.running_xor != parse.checksum_byte)
            w.packet_status = mfp_pkg::STATUS_CHECKSUM;
         else
            w.packet_status = mfp_pkg::STATUS_OK;
         expected_q.push_back(w);
         parse = mfp_pkg::FRAME_STATE_CLEAR;
      end else if (is_payload) begin
         w.result_kind      = mfp_pkg::KIND_PAYLOAD;
         w.payload_value    = b;
         w.payload_position = ppos;
         expected_q.push_back(w);
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("rsp %s: expected 0x%02h, got 0x%02h", name, want, got);
         mismatch_total++;
      end
   endtask

   task automatic check_word(input mfp_pkg::rsp_word_type got);
      mfp_pkg::rsp_word_type want;
      if (expected_q.size() == 0) begin
         $error("rsp word 0x%h arrived with nothing expected", got);
         mismatch_total++;
      end else begin
         want = expected_q.pop_front();
         compare_field("result_kind", {7'd0, want.result_kind}, {7'd0, got.result_kind});
         compare_field("payload_value", want.payload_value, got.payload_value);
         compare_field("payload_position", want.payload_position, got.payload_position);
         compare_field("packet_status", {5'd0, want.packet_status},
                       {5'd0, got.packet_status});
         compare_field("direction_code", {6'd0, want.direction_code},
                       {6'd0, got.direction_code});
         compare_field("command_code", want.command_code, got.command_code);
         compare_field("payload_length", want.payload_length, got.payload_length);
         if (want.result_kind == mfp_pkg::KIND_STATUS) begin
            status_total++;
            seen_status[want.packet_status] = 1'b1;
         end else begin
            payload_total++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hdr_first     = mfp_pkg::HEADER_FIRST_RESET;
         hdr_second    = mfp_pkg::HEADER_SECOND_RESET;
         cmd_valid_map = '0;
         parse         = mfp_pkg::FRAME_STATE_CLEAR;
         expected_q.delete();
      end else begin
         if (csr_write_en === 1'b1) apply_write(csr_index, csr_write_data);
         if (req_valid === 1'b1 && req_stall === 1'b0)
            parse_byte(req_word.frame_byte, req_word.packet_end);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) check_word(rsp_word);
      end
      waiting = expected_q.size();
   end

endmodule

@@ dv/msp_frame_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msp_frame_parser_unit_tb - frame parser testbench top
// Drives MSP frames (well-formed, corrupted and noise) through the parser
// under several header and command-map settings with random idling on both
// channels; the scoreboard beside the block predicts and checks each word.
// ----------------------------------------------------------------------------
module msp_frame_parser_unit_tb;

   localparam int HALF_PERIOD       = 5;
   localparam int RESET_CYCLES      = 11;
   localparam int IDLE_PERCENT      = 13;
   localparam int HOLD_CYCLES       = 120;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int PHASE_ITEMS       = 36;
   localparam int HOLD_AFTER_ITEMS  = 12;
   localparam int DRAIN_CYCLES      = 4;
   localparam int LONG_PACKET_BYTES = 516;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   mfp_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   mfp_pkg::rsp_word_type rsp_word;
   logic                  csr_write_en = 1'b0;
   logic [2:0]            csr_index = mfp_pkg::CSR_HEADER_FIRST;
   logic [63:0]           csr_write_data = '0;

   int            error_count;
   int            pending_count;
   int            status_words;
   int            payload_words;
   logic [4:0]    status_mask;

   // register mirror, used only to shape the stimulus
   logic [7:0]    cur_hdr_first = mfp_pkg::HEADER_FIRST_RESET;
   logic [7:0]    cur_hdr_second = mfp_pkg::HEADER_SECOND_RESET;
   logic [255:0]  cur_cmd_map = '0;

   logic [7:0]    pkt[$];
   logic          calm = 1'b0;     // suppress idling on both sides
   logic          hold_go = 1'b0;  // request one long receiver hold-off
   int            items_sent = 0;
   int            settings_used = 0;
   int            quiet_cycles = 0;

   always #HALF_PERIOD clock = ~clock;

   msp_frame_parser_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   msp_frame_parser_unit_check u_frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .status_words   (status_words),
      .payload_words  (payload_words),
      .status_mask    (status_mask)
   );

   // Receiver: stall at random, or hold off for a long stretch on request.
   // The hold-off is counted here so the sender keeps pushing and the
   // parser backs up into its input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Watchdog: end the run if no word, response or register write moves
   // for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Write one register; the caller drops the enable after its last write.
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // Load all six registers. Header writes carry junk in the upper bits,
   // which the block must drop.
   task automatic load_config(input logic [7:0] h0, input logic [7:0] h1,
                              input logic [255:0] map);
      cur_hdr_first  = h0;
      cur_hdr_second = h1;
      cur_cmd_map    = map;
      write_reg(mfp_pkg::CSR_HEADER_FIRST,
                {$urandom(), 24'($urandom_range(16777215)), h0});
      write_reg(mfp_pkg::CSR_HEADER_SECOND,
                {$urandom(), 24'($urandom_range(16777215)), h1});
      write_reg(mfp_pkg::CSR_CMD_VALID0, map[63:0]);
      write_reg(mfp_pkg::CSR_CMD_VALID1, map[127:64]);
      write_reg(mfp_pkg::CSR_CMD_VALID2, map[191:128]);
      write_reg(mfp_pkg::CSR_CMD_VALID3, map[255:192]);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [255:0] random_map();
      logic [255:0] m;
      for (int i = 0; i < 8; i++) m[i*32 +: 32] = $urandom();
      return m;
   endfunction

   // Prefer a command the current map accepts; fall back to any code.
   function automatic logic [7:0] pick_command();
      logic [7:0] c;
      for (int i = 0; i < 16; i++) begin
         c = 8'($urandom_range(255));
         if (cur_cmd_map[c]) return c;
      end
      return 8'($urandom_range(255));
   endfunction

   // Offer one word; idle first now and then. Valid stays high straight
   // through back-to-back words.
   task automatic push_byte(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_word.frame_byte <= b;
      req_word.packet_end <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt.size(); i++) push_byte(pkt[i], i == pkt.size() - 1);
   endtask

   // Build one random packet: mostly well-formed frames, some with a single
   // defect, the rest noise.
   task automatic build_packet();
      int         sel;
      int         len;
      int         n;
      logic [7:0] cmd;
      logic [7:0] sum;
      logic [7:0] b;
      pkt.delete();
      sel = $urandom_range(99);
      if (sel >= 85) begin
         n = $urandom_range(1, 12);
         if ($urandom_range(1)) begin
            pkt.push_back(cur_hdr_first);
            pkt.push_back(cur_hdr_second);
         end
         while (pkt.size() < n) pkt.push_back(8'($urandom_range(255)));
         return;
      end
      len = ($urandom_range(19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      cmd = pick_command();
      sum = len[7:0] ^ cmd;
      pkt.push_back(cur_hdr_first);
      pkt.push_back(cur_hdr_second);
      pkt.push_back($urandom_range(1) ? mfp_pkg::DIR_BYTE_IN : mfp_pkg::DIR_BYTE_OUT);
      pkt.push_back(len[7:0]);
      pkt.push_back(cmd);
      for (int i = 0; i < len; i++) begin
         b   = 8'($urandom_range(255));
         sum = sum ^ b;
         pkt.push_back(b);
      end
      pkt.push_back(sum);
      // pad an empty frame to the minimum size, sometimes add trailing bytes
      n = (pkt.size() < mfp_pkg::MIN_FRAME_BYTES) ? 1 : 0;
      if ($urandom_range(4) == 0) n += $urandom_range(1, 3);
      repeat (n) pkt.push_back(8'($urandom_range(255)));
      if (sel >= 60) begin
         case ($urandom_range(5))
            0: pkt[0] = pkt[0] ^ (8'd1 << $urandom_range(7));
            1: pkt[1] = pkt[1] ^ (8'd1 << $urandom_range(7));
            2: pkt[2] = 8'($urandom_range(255));
            3: begin
               // swap the command but keep the checksum consistent
               b = 8'($urandom_range(255));
               pkt[5 + len] = pkt[5 + len] ^ cmd ^ b;
               pkt[4] = b;
            end
            4: pkt[5 + len] = pkt[5 + len] ^ (8'd1 << $urandom_range(7));
            default: begin
               n = $urandom_range(1, pkt.size() - 1);
               while (pkt.size() > n) void'(pkt.pop_back());
            end
         endcase
      end
   endtask

   // Drop valid, let every expected word come back, then let the block idle
   // for a drain period before the registers are touched.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [255:0] map;
      logic [7:0]   cmd;
      logic [7:0]   sum;
      logic [7:0]   b;
      int           phase_start;
      logic         held;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme command codes valid, default header.
      map = random_map();
      map[8'h00] = 1'b1;
      map[8'hFF] = 1'b1;
      load_config(mfp_pkg::HEADER_FIRST_RESET, mfp_pkg::HEADER_SECOND_RESET, map);

      // wrong first header byte, packet of one byte
      pkt = '{8'h00};
      send_packet();
      // good header byte, then the packet ends: too short
      pkt = '{mfp_pkg::HEADER_FIRST_RESET};
      send_packet();
      // empty payload, command 0xFF, one trailing byte to reach seven
      pkt = '{mfp_pkg::HEADER_FIRST_RESET, mfp_pkg::HEADER_SECOND_RESET,
              mfp_pkg::DIR_BYTE_OUT, 8'h00, 8'hFF, 8'hFF, 8'h00};
      send_packet();
      // one payload byte at 0xFF, checksum off by one bit
      pkt = '{mfp_pkg::HEADER_FIRST_RESET, mfp_pkg::HEADER_SECOND_RESET,
              mfp_pkg::DIR_BYTE_IN, 8'h01, 8'h00, 8'hFF, 8'h01 ^ 8'hFF ^ 8'h01};
      send_packet();
      // packet ends on a payload byte: only the status word comes out
      pkt = '{mfp_pkg::HEADER_FIRST_RESET, mfp_pkg::HEADER_SECOND_RESET,
              mfp_pkg::DIR_BYTE_IN, 8'h03, 8'h00, 8'hFF};
      send_packet();
      // unknown direction byte
      pkt = '{mfp_pkg::HEADER_FIRST_RESET, mfp_pkg::HEADER_SECOND_RESET, 8'h7F, 8'h00,
              8'h00, 8'h00, 8'h00};
      send_packet();
      settle();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: load_config(mfp_pkg::HEADER_FIRST_RESET, mfp_pkg::HEADER_SECOND_RESET,
                           random_map());
            1: load_config(8'h00, 8'hFF, '1);
            2: load_config(8'hFF, 8'h00, '0);
            default: load_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 random_map());
         endcase
         // run the whole third phase without idling on either side
         calm        = (phase == 2);
         held        = 1'b0;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            // early in the second phase, stop the receiver for a while
            if (phase == 1 && !held && items_sent - phase_start > HOLD_AFTER_ITEMS) begin
               hold_go = 1'b1;
               held    = 1'b1;
            end
            build_packet();
            send_packet();
         end
         settle();
      end
      calm = 1'b0;

      // Long packet: full 255-byte payload, then trailing bytes past the
      // point where the byte count saturates.
      load_config(mfp_pkg::HEADER_FIRST_RESET, mfp_pkg::HEADER_SECOND_RESET, random_map());
      cmd = pick_command();
      sum = 8'hFF ^ cmd;
      pkt.delete();
      pkt.push_back(cur_hdr_first);
      pkt.push_back(cur_hdr_second);
      pkt.push_back(mfp_pkg::DIR_BYTE_OUT);
      pkt.push_back(8'hFF);
      pkt.push_back(cmd);
      repeat (255) begin
         b   = 8'($urandom_range(255));
         sum = sum ^ b;
         pkt.push_back(b);
      end
      pkt.push_back(sum);
      while (pkt.size() < LONG_PACKET_BYTES) pkt.push_back(8'($urandom_range(255)));
      send_packet();
      // make sure parsing restarts cleanly after it
      repeat (2) begin
         build_packet();
         send_packet();
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d words sent, %0d packet statuses and %0d payload bytes checked",
               items_sent, status_words, payload_words);
      $display("summary: %0d register settings, statuses seen (bit per code) %b",
               settings_used, status_mask);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ msp_frame_parser_unit.f @@
rtl/mfp_pkg.sv
rtl/mfp_byte_decode.sv
rtl/msp_frame_parser_unit.sv
dv/msp_frame_parser_unit_check.sv
dv/msp_frame_parser_unit_tb.sv
